>>> sv/rrv_pkg.sv
// Shared types and constants for the rounded rectangle vertex generator.
package rrv_pkg;

  localparam int COORD_W = 24;
  localparam int OUT_W   = 25;
  localparam int QW      = 17;
  localparam int XYW     = 20;
  localparam int ZW      = 19;
  localparam int CORDIC_STEPS = 16;
  localparam int PROD_W  = 45;

  localparam logic [QW-1:0]  HALF_PI_Q16 = 17'd102944;
  localparam logic [XYW-1:0] CORDIC_GAIN = 20'd39797;

  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_CORNER_RADIUS = 2'd2;
  localparam logic [1:0] CFG_CORNER_POINTS = 2'd3;

  typedef struct packed {
    logic       in_range;
    logic [1:0] quad;
  } tag_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 19'sd51472;
      1:  a = 19'sd30385;
      2:  a = 19'sd16055;
      3:  a = 19'sd8150;
      4:  a = 19'sd4091;
      5:  a = 19'sd2047;
      6:  a = 19'sd1024;
      7:  a = 19'sd512;
      8:  a = 19'sd256;
      9:  a = 19'sd128;
      10: a = 19'sd64;
      11: a = 19'sd32;
      12: a = 19'sd16;
      13: a = 19'sd8;
      14: a = 19'sd4;
      default: a = 19'sd2;
    endcase
    return a;
  endfunction

endpackage

>>> sv/rrv_divide.sv
// Pipelined restoring divider, one quotient bit per stage, for the arc angle.
module rrv_divide #(
  parameter int NW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic [NW+rrv_pkg::QW-1:0] num,
  input  logic [NW-1:0]        den,
  input  rrv_pkg::tag_t        in_tag,
  output logic                 out_v,
  output logic [rrv_pkg::QW-1:0] quot,
  output rrv_pkg::tag_t        out_tag
);

  localparam int QW = rrv_pkg::QW;

  // Each stage holds the partial remainder and the dividend bits still to be
  // consumed; quotient bits shift in from the bottom as dividend bits leave.
  logic [NW-1:0]     rem  [0:QW];
  logic [QW-1:0]     lowq [0:QW];
  logic [NW-1:0]     dd   [0:QW];
  rrv_pkg::tag_t     tg   [0:QW];
  logic [QW:0]       v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_v;
    end
    if (adv) begin
      rem[0]  <= num[NW+QW-1:QW];
      lowq[0] <= num[QW-1:0];
      dd[0]   <= den;
      tg[0]   <= in_tag;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [NW:0] trial;
    logic        ge;
    assign trial = {rem[s], lowq[s][QW-1]};
    assign ge    = (trial >= {1'b0, dd[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
      if (adv) begin
        rem[s+1]  <= ge ? NW'(trial - {1'b0, dd[s]}) : trial[NW-1:0];
        lowq[s+1] <= {lowq[s][QW-2:0], ge};
        dd[s+1]   <= dd[s];
        tg[s+1]   <= tg[s];
      end
    end
  end

  assign out_v   = v[QW];
  assign quot    = lowq[QW];
  assign out_tag = tg[QW];

endmodule

>>> sv/rrv_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module rrv_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [rrv_pkg::QW-1:0]        angle,
  input  rrv_pkg::tag_t                 in_tag,
  output logic                          out_v,
  output logic signed [rrv_pkg::XYW-1:0] cos_q,
  output logic signed [rrv_pkg::XYW-1:0] sin_q,
  output rrv_pkg::tag_t                 out_tag
);

  localparam int N   = rrv_pkg::CORDIC_STEPS;
  localparam int XYW = rrv_pkg::XYW;
  localparam int ZW  = rrv_pkg::ZW;

  logic signed [XYW-1:0] x [0:N];
  logic signed [XYW-1:0] y [0:N];
  logic signed [ZW-1:0]  z [0:N];
  rrv_pkg::tag_t         tg [0:N];
  logic [N:0]            v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_v;
    end
    if (adv) begin
      x[0]  <= rrv_pkg::CORDIC_GAIN;
      y[0]  <= '0;
      z[0]  <= $signed({{(ZW-rrv_pkg::QW){1'b0}}, angle});
      tg[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XYW-1:0] dx, dy;
    assign dx = x[i] >>> i;
    assign dy = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
      if (adv) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - dy;
          y[i+1] <= y[i] + dx;
          z[i+1] <= z[i] - rrv_pkg::atan_q16(i);
        end else begin
          x[i+1] <= x[i] + dy;
          y[i+1] <= y[i] - dx;
          z[i+1] <= z[i] + rrv_pkg::atan_q16(i);
        end
        tg[i+1] <= tg[i];
      end
    end
  end

  assign out_v   = v[N];
  assign cos_q   = x[N];
  assign sin_q   = y[N];
  assign out_tag = tg[N];

endmodule

>>> sv/rounded_rect_vertex_gen.sv
// Top level: index decode, angle divider, CORDIC, radius scaling and output.
//
//   channel  signals                               direction
//   in       in_valid, in_stall, vertex_index      item enters
//   out      out_valid, out_stall, point_x/y,      result leaves
//            in_range
//   cfg      cfg_we, cfg_index, cfg_data           register write
//
// One point per cycle while the output is not held. The pipeline has two decode
// stages, 18 divider stages (an input register and one per quotient bit), 17
// CORDIC stages, a multiply stage and the output register. Reset clears all valid bits and loads the register defaults.
// A held output stalls the whole pipeline in lockstep, so nothing is lost or
// repeated.
module rounded_rect_vertex_gen #(
  parameter int MAX_CORNER_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rrv_pkg::COORD_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         vertex_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rrv_pkg::OUT_W-1:0]   point_x,
  output logic signed [rrv_pkg::OUT_W-1:0]   point_y,
  output logic                               in_range
);

  localparam int NW  = $clog2(MAX_CORNER_POINTS + 1);
  localparam int IW  = NW + 10;
  localparam int QW  = rrv_pkg::QW;
  localparam int XYW = rrv_pkg::XYW;
  localparam int CW  = rrv_pkg::COORD_W;
  localparam int PW  = rrv_pkg::PROD_W;

  logic [CW-1:0] frame_width, frame_height, corner_radius;
  logic [6:0]    corner_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= '0;
      frame_height  <= '0;
      corner_radius <= '0;
      corner_points <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrv_pkg::CFG_FRAME_WIDTH:   frame_width   <= cfg_data;
        rrv_pkg::CFG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        rrv_pkg::CFG_CORNER_RADIUS: corner_radius <= cfg_data;
        rrv_pkg::CFG_CORNER_POINTS: corner_points <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Clamped point count.
  logic [NW-1:0] n;
  always_comb begin
    if (corner_points < 7'd2) begin
      n = NW'(2);
    end else if (32'(corner_points) > 32'(MAX_CORNER_POINTS)) begin
      n = NW'(MAX_CORNER_POINTS);
    end else begin
      n = NW'(corner_points);
    end
  end

  // Stage 1: input register.
  logic       v1;
  logic [7:0] idx1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      idx1 <= vertex_index;
    end
  end

  // Corner and point split by compares against n, 2n and 3n.
  logic [IW-1:0] idx_w, n1, n2, n3, n4, j_w;
  logic [1:0]    k1;
  assign idx_w = IW'(idx1);
  assign n1    = IW'(n);
  assign n2    = n1 << 1;
  assign n3    = n2 + n1;
  assign n4    = n1 << 2;
  always_comb begin
    priority if (idx_w >= n3) begin
      k1 = 2'd3; j_w = idx_w - n3;
    end else if (idx_w >= n2) begin
      k1 = 2'd2; j_w = idx_w - n2;
    end else if (idx_w >= n1) begin
      k1 = 2'd1; j_w = idx_w - n1;
    end else begin
      k1 = 2'd0; j_w = idx_w;
    end
  end

  // Stage 2: corner, point, range flag.
  logic          v2;
  logic [NW-1:0] j2;
  rrv_pkg::tag_t tag2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      j2            <= j_w[NW-1:0];
      tag2.quad     <= k1;
      tag2.in_range <= (idx_w < n4);
    end
  end

  logic [NW-1:0]    den;
  logic [NW+QW-1:0] num;
  assign den = n - NW'(1);
  assign num = (NW+QW)'(j2) * (NW+QW)'(rrv_pkg::HALF_PI_Q16) + (NW+QW)'(den >> 1);

  logic          vd;
  logic [QW-1:0] ang;
  rrv_pkg::tag_t tagd;

  rrv_divide #(.NW(NW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (v2),
    .num     (num),
    .den     (den),
    .in_tag  (tag2),
    .out_v   (vd),
    .quot    (ang),
    .out_tag (tagd)
  );

  logic                  vc;
  logic signed [XYW-1:0] c, s;
  rrv_pkg::tag_t         tagc;

  rrv_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (vd),
    .angle   (ang),
    .in_tag  (tagd),
    .out_v   (vc),
    .cos_q   (c),
    .sin_q   (s),
    .out_tag (tagc)
  );

  // Quadrant rotation and arc centre.
  logic signed [XYW-1:0] cs, sn;
  logic signed [CW+1:0]  cx, cy, r_s, w_s, h_s;
  assign r_s = $signed({2'b00, corner_radius});
  assign w_s = $signed({2'b00, frame_width});
  assign h_s = $signed({2'b00, frame_height});
  always_comb begin
    unique case (tagc.quad)
      2'd0:    begin cs = c;  sn = s;  end
      2'd1:    begin cs = -s; sn = c;  end
      2'd2:    begin cs = -c; sn = -s; end
      default: begin cs = s;  sn = -c; end
    endcase
    cx = (tagc.quad == 2'd0 || tagc.quad == 2'd3) ? w_s - r_s : r_s;
    cy = (tagc.quad == 2'd2 || tagc.quad == 2'd3) ? h_s - r_s : r_s;
  end

  logic signed [CW:0] r_m;
  assign r_m = $signed({1'b0, corner_radius});

  // Multiply stage.
  logic                 vm;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [CW+1:0] cx_m, cy_m;
  logic                 inr_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vc;
    end
    if (adv) begin
      prod_x <= r_m * cs;
      prod_y <= r_m * sn;
      cx_m   <= cx;
      cy_m   <= cy;
      inr_m  <= tagc.in_range;
    end
  end

  // Round half up to 16.8, offset by the centre, saturate.
  localparam int SW = PW + 1;
  logic signed [SW-1:0] rx, ry, sx, sy;
  logic signed [rrv_pkg::OUT_W-1:0] qx, qy;
  localparam logic signed [SW-1:0] OMIN = -(SW'(1) <<< 24);
  localparam logic signed [SW-1:0] OMAX = (SW'(1) <<< 24) - SW'(1);
  assign rx = (SW'(prod_x) + SW'(32768)) >>> 16;
  assign ry = (SW'(prod_y) + SW'(32768)) >>> 16;
  assign sx = SW'(cx_m) + rx;
  assign sy = SW'(cy_m) - ry;
  always_comb begin
    priority if (sx < OMIN) qx = OMIN[rrv_pkg::OUT_W-1:0];
    else if (sx > OMAX)     qx = OMAX[rrv_pkg::OUT_W-1:0];
    else                    qx = sx[rrv_pkg::OUT_W-1:0];
    priority if (sy < OMIN) qy = OMIN[rrv_pkg::OUT_W-1:0];
    else if (sy > OMAX)     qy = OMAX[rrv_pkg::OUT_W-1:0];
    else                    qy = sy[rrv_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vm;
    end
    if (adv) begin
      point_x  <= inr_m ? qx : '0;
      point_y  <= inr_m ? qy : '0;
      in_range <= inr_m;
    end
  end

endmodule
